FILE: rtl/pavm_pkg.sv
// Shared types and codes for the polyphonic ADSR voice mixer.
// Depends on nothing; the top level and the checker import it.
package pavm_pkg;

    typedef enum logic [1:0] {
        REQ_TICK     = 2'd0,
        REQ_NOTE_ON  = 2'd1,
        REQ_NOTE_OFF = 2'd2,
        REQ_SPARE    = 2'd3
    } req_code_t;

    typedef enum logic [1:0] {
        ST_ATTACK  = 2'd0,
        ST_DECAY   = 2'd1,
        ST_SUSTAIN = 2'd2,
        ST_RELEASE = 2'd3
    } stage_t;

    typedef enum logic [2:0] {
        REG_SINE_WEIGHT   = 3'd0,
        REG_SAW_WEIGHT    = 3'd1,
        REG_SQUARE_WEIGHT = 3'd2,
        REG_ATTACK_RATE   = 3'd3,
        REG_DECAY_RATE    = 3'd4,
        REG_SUSTAIN_LEVEL = 3'd5,
        REG_RELEASE_RATE  = 3'd6,
        REG_OUTPUT_GAIN   = 3'd7
    } cfg_reg_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ON_MUL,
        S_ON_DIV,
        S_ON_WR,
        S_WALK,
        S_GAIN,
        S_DONE
    } fsm_state_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  key;
        logic [7:0]  velocity;
        logic [23:0] phase_step;
    } req_t;

    typedef struct packed {
        logic signed [23:0] sample;
        logic [8:0]         voices_active;
    } rsp_t;

endpackage

FILE: rtl/pavm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pavm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/pavm_sine_rom.sv
// Sine lookup ROM, built at elaboration from a fixed-point Taylor series.
// Registered read; no package dependencies.
module pavm_sine_rom #(
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic [$clog2(DEPTH)-1:0] addr,
    output logic signed [16:0]       data
);

    localparam int AW = $clog2(DEPTH);
    localparam logic [63:0] Q30_ONE     = 64'h4000_0000;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef logic signed [16:0] rom_t [DEPTH];

    function automatic logic signed [16:0] sine_entry(input int unsigned idx);
        logic [63:0]        t;
        logic [63:0]        r;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        h;
        logic [63:0]        s;
        logic [63:0]        v;
        logic [1:0]         q;
        logic signed [16:0] e;
        t = 64'(idx) << (32 - AW);
        q = t[31:30];
        r = {34'd0, t[29:0]};
        if (q[0])
        begin
            r = Q30_ONE - r;
        end
        x  = (r * HALF_PI_Q30) >> 30;
        x2 = (x * x) >> 30;
        h  = Q30_ONE;
        h  = Q30_ONE - ((x2 * h) >> 30) / 72;
        h  = Q30_ONE - ((x2 * h) >> 30) / 42;
        h  = Q30_ONE - ((x2 * h) >> 30) / 20;
        h  = Q30_ONE - ((x2 * h) >> 30) / 6;
        s  = (x * h) >> 30;
        v  = (s * 64'd32768 + (Q30_ONE >> 1)) >> 30;
        if (v > 64'd32768)
        begin
            v = 64'd32768;
        end
        e = 17'(v);
        return q[1] ? -e : e;
    endfunction

    function automatic rom_t build_rom();
        rom_t r;
        for (int i = 0; i < DEPTH; i++)
        begin
            r[i] = sine_entry(i);
        end
        return r;
    endfunction

    localparam rom_t ROM = build_rom();

    always_ff @(posedge clk)
    begin
        data <= ROM[addr];
    end

endmodule

FILE: rtl/polyphonic_adsr_voice_mixer.sv
// Top level of the polyphonic ADSR voice mixer: slot walk, envelopes, mix, gain.
// Depends on pavm_pkg, pavm_ram and pavm_sine_rom.
//
// Usage
//   Requests arrive on req (valid/ready): a sample tick, a note-on or a note-off.
//   Only a tick gives a response on rsp (valid/ready): the mixed sample after
//   gain, saturated to 24 bits, and the count of sounding slots.
//   Note-on runs S_ON_MUL, S_ON_DIV, S_ON_WR; note events give no response.
//   A tick walks every slot through the slot memories, one slot read per cycle
//   on the single read port, then a five-stage envelope/mix pipeline drains and
//   the gain stage runs before the response is registered.
//   No new request is taken during the walk: a tick holds req_ready low until
//   it is done and the block is back in S_IDLE.
//   Reset clears the active and held flags and restores register defaults;
//   the slot memories need no clearing since only active slots are used.
//   The response sits in an output register: a new request is accepted while
//   it waits, but a finished tick holds in its last state until rsp is free.
//   APB port settings must only be written when idle; the block does not check.
module polyphonic_adsr_voice_mixer #(
    parameter int VOICE_SLOTS      = 256,
    parameter int PHASE_BITS       = 24,
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int LEVEL_BITS       = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    // request channel
    input  logic           req_valid,
    output logic           req_ready,
    input  pavm_pkg::req_t req,
    // response channel
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output pavm_pkg::rsp_t rsp,
    // APB settings port
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [4:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);

    import pavm_pkg::*;

    localparam int SLOT_W  = $clog2(VOICE_SLOTS);
    localparam int TAB_W   = $clog2(SINE_TABLE_DEPTH);
    localparam int LB      = LEVEL_BITS;
    localparam int PB      = PHASE_BITS;
    localparam int STEP_W  = LB + 1;
    localparam int MIX_W   = 34;
    localparam int PROD_W  = MIX_W + LB + 1;
    localparam int ACC_W   = 30 + SLOT_W;
    localparam int GAIN_W  = ACC_W + 17;
    localparam logic [LB-1:0]           LEVEL_MAX = '1;
    localparam logic [63:0]             DIV255_MAGIC = 64'h8080_8081;
    localparam logic signed [GAIN_W-1:0] SAT_HI = GAIN_W'(8388607);
    localparam logic signed [GAIN_W-1:0] SAT_LO = -SAT_HI - GAIN_W'(1);

    // slot memory A: running level and phase
    typedef struct packed {
        logic [LB-1:0] level;
        logic [PB-1:0] phase;
    } slot_a_t;

    // slot memory B: envelope stage, peak level, step, phase increment
    typedef struct packed {
        stage_t                   stage;
        logic [LB-1:0]            pk;
        logic signed [STEP_W-1:0] step;
        logic [23:0]              phst;
    } slot_b_t;

    // ---------------- settings ----------------
    logic signed [15:0] sine_w_reg;
    logic signed [15:0] saw_w_reg;
    logic signed [15:0] square_w_reg;
    logic [15:0]        attack_reg;
    logic [15:0]        decay_reg;
    logic [15:0]        sustain_reg;
    logic [15:0]        release_reg;
    logic [15:0]        gain_reg;
    logic               cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sine_w_reg   <= '0;
            saw_w_reg    <= '0;
            square_w_reg <= 16'sd16384;
            attack_reg   <= 16'hFFFF;
            decay_reg    <= 16'hFFFF;
            sustain_reg  <= '0;
            release_reg  <= 16'hFFFF;
            gain_reg     <= 16'h8000;
        end
        else if (cfg_wr)
        begin
            case (cfg_reg_t'(paddr[4:2]))
                REG_SINE_WEIGHT:   sine_w_reg   <= pwdata[15:0];
                REG_SAW_WEIGHT:    saw_w_reg    <= pwdata[15:0];
                REG_SQUARE_WEIGHT: square_w_reg <= pwdata[15:0];
                REG_ATTACK_RATE:   attack_reg   <= pwdata[15:0];
                REG_DECAY_RATE:    decay_reg    <= pwdata[15:0];
                REG_SUSTAIN_LEVEL: sustain_reg  <= pwdata[15:0];
                REG_RELEASE_RATE:  release_reg  <= pwdata[15:0];
                REG_OUTPUT_GAIN:   gain_reg     <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_reg_t'(paddr[4:2]))
            REG_SINE_WEIGHT:   prdata = {16'd0, sine_w_reg};
            REG_SAW_WEIGHT:    prdata = {16'd0, saw_w_reg};
            REG_SQUARE_WEIGHT: prdata = {16'd0, square_w_reg};
            REG_ATTACK_RATE:   prdata = {16'd0, attack_reg};
            REG_DECAY_RATE:    prdata = {16'd0, decay_reg};
            REG_SUSTAIN_LEVEL: prdata = {16'd0, sustain_reg};
            REG_RELEASE_RATE:  prdata = {16'd0, release_reg};
            REG_OUTPUT_GAIN:   prdata = {16'd0, gain_reg};
            default:           prdata = '0;
        endcase
    end

    // ---------------- control ----------------
    fsm_state_t state_reg;
    fsm_state_t state_next;

    logic                   accept;
    logic                   key_ok;
    logic [SLOT_W-1:0]      key_idx;
    logic                   on_ok;
    logic                   issue;
    logic                   on_write;
    logic                   rsp_load;
    logic                   walk_done;
    logic [SLOT_W:0]        k_reg;

    logic [VOICE_SLOTS-1:0] active_reg;
    logic [VOICE_SLOTS-1:0] held_reg;

    // pipeline valid flags
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;

    assign accept  = req_valid && req_ready;
    assign key_ok  = 9'(req.key) < 9'(VOICE_SLOTS);
    assign key_idx = req.key[SLOT_W-1:0];
    assign on_ok   = key_ok && !(active_reg[key_idx] && held_reg[key_idx]);
    assign walk_done = (k_reg == (SLOT_W+1)'(VOICE_SLOTS))
                       && !v1_reg && !v2_reg && !v3_reg && !v4_reg && !v5_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req.req_type == REQ_TICK)
                    begin
                        state_next = S_WALK;
                    end
                    else if (req.req_type == REQ_NOTE_ON && on_ok)
                    begin
                        state_next = S_ON_MUL;
                    end
                end
            end
            S_ON_MUL: state_next = S_ON_DIV;
            S_ON_DIV: state_next = S_ON_WR;
            S_ON_WR:  state_next = S_IDLE;
            S_WALK:
            begin
                if (walk_done)
                begin
                    state_next = S_GAIN;
                end
            end
            S_GAIN:   state_next = S_DONE;
            S_DONE:
            begin
                if (!rsp_valid || rsp_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        req_ready = 1'b0;
        on_write  = 1'b0;
        rsp_load  = 1'b0;
        issue     = 1'b0;
        case (state_reg)
            S_IDLE:  req_ready = 1'b1;
            S_ON_WR: on_write  = 1'b1;
            S_WALK:  issue     = k_reg < (SLOT_W+1)'(VOICE_SLOTS);
            S_DONE:  rsp_load  = !rsp_valid || rsp_ready;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // ---------------- note-on path ----------------
    logic [SLOT_W-1:0] on_key_reg;
    logic [7:0]        on_vel_reg;
    logic [23:0]       on_phst_reg;
    logic              on_fresh_reg;
    logic [LB+7:0]     on_x_reg;
    logic [LB-1:0]     on_pk_reg;
    logic [63:0]       div_p;
    logic [LB+15:0]    att_p;

    assign div_p = 64'(on_x_reg) * DIV255_MAGIC;   // x / 255, exact for 32-bit x
    assign att_p = (LB+16)'(on_pk_reg) * (LB+16)'(attack_reg);

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            on_key_reg   <= key_idx;
            on_vel_reg   <= req.velocity;
            on_phst_reg  <= req.phase_step;
            on_fresh_reg <= !active_reg[key_idx];
        end
        on_x_reg  <= (LB+8)'(on_vel_reg) * (LB+8)'(LEVEL_MAX);
        on_pk_reg <= div_p[39 +: LB];
    end

    // ---------------- slot memories ----------------
    logic              a_we, b_we;
    logic [SLOT_W-1:0] a_waddr, b_waddr;
    slot_a_t           a_wdata, a_rdata;
    slot_b_t           b_wdata, b_rdata;
    logic              wb_we;
    logic [SLOT_W-1:0] idx3_reg;
    slot_a_t           wb_a;
    slot_b_t           wb_b;
    slot_a_t           on_a;
    slot_b_t           on_b;

    assign on_a.level = '0;
    assign on_a.phase = '0;
    assign on_b.stage = ST_ATTACK;
    assign on_b.pk    = on_pk_reg;
    assign on_b.step  = $signed({1'b0, att_p[LB+15:16]});
    assign on_b.phst  = on_phst_reg;

    assign a_we    = wb_we || (on_write && on_fresh_reg);
    assign b_we    = wb_we || on_write;
    assign a_waddr = on_write ? on_key_reg : idx3_reg;
    assign b_waddr = on_write ? on_key_reg : idx3_reg;
    assign a_wdata = on_write ? on_a : wb_a;
    assign b_wdata = on_write ? on_b : wb_b;

    pavm_ram #(.WIDTH($bits(slot_a_t)), .DEPTH(VOICE_SLOTS)) u_mem_a (
        .clk   (clk),
        .we    (a_we),
        .waddr (a_waddr),
        .wdata (a_wdata),
        .raddr (k_reg[SLOT_W-1:0]),
        .rdata (a_rdata)
    );

    pavm_ram #(.WIDTH($bits(slot_b_t)), .DEPTH(VOICE_SLOTS)) u_mem_b (
        .clk   (clk),
        .we    (b_we),
        .waddr (b_waddr),
        .wdata (b_wdata),
        .raddr (k_reg[SLOT_W-1:0]),
        .rdata (b_rdata)
    );

    // ---------------- walk, stage 1: memory data back ----------------
    // Each slot is read once and written at most once per tick; nothing else
    // touches the memories until the pipe drains, so no forwarding is needed.
    logic              act1_reg, held1_reg;
    logic [SLOT_W-1:0] idx1_reg;
    logic [LB+15:0]    m_sus1;
    logic [LB+16:0]    m_dec1;
    logic [PB+23:0]    inc_w;
    logic [PB-1:0]     newph1;
    logic signed [15:0] saw1;
    logic signed [16:0] sine2;

    always_ff @(posedge clk)
    begin
        act1_reg  <= active_reg[k_reg[SLOT_W-1:0]];
        held1_reg <= held_reg[k_reg[SLOT_W-1:0]];
        idx1_reg  <= k_reg[SLOT_W-1:0];
    end

    assign m_sus1 = (LB+16)'(b_rdata.pk) * (LB+16)'(sustain_reg);
    assign m_dec1 = (LB+17)'(b_rdata.pk) * (LB+17)'(17'h10000 - {1'b0, sustain_reg});
    assign inc_w  = (PB+24)'(b_rdata.phst) << PB;
    assign newph1 = a_rdata.phase + inc_w[24 +: PB];
    assign saw1   = {~a_rdata.phase[PB-1], a_rdata.phase[PB-2 -: 15]};

    pavm_sine_rom #(.DEPTH(SINE_TABLE_DEPTH)) u_sine (
        .clk  (clk),
        .addr (a_rdata.phase[PB-1 -: TAB_W]),
        .data (sine2)
    );

    // ---------------- stage 2: envelope steps and wave mix ----------------
    logic                     act2_reg, held2_reg, sqneg2_reg;
    logic [SLOT_W-1:0]        idx2_reg;
    stage_t                   stage2_reg;
    logic [LB-1:0]            pk2_reg, level2_reg;
    logic signed [STEP_W-1:0] step2_reg;
    logic [23:0]              phst2_reg;
    logic [PB-1:0]            newph2_reg;
    logic [LB+15:0]           m_sus2_reg;
    logic [LB+16:0]           m_dec2_reg;
    logic signed [15:0]       saw2_reg;
    logic [LB+31:0]           rel_p;
    logic [LB+32:0]           dec_p;
    logic signed [MIX_W-1:0]  t_sine, t_saw, t_sq, mix2;

    always_ff @(posedge clk)
    begin
        act2_reg   <= act1_reg;
        held2_reg  <= held1_reg;
        idx2_reg   <= idx1_reg;
        stage2_reg <= b_rdata.stage;
        pk2_reg    <= b_rdata.pk;
        step2_reg  <= b_rdata.step;
        phst2_reg  <= b_rdata.phst;
        level2_reg <= a_rdata.level;
        newph2_reg <= newph1;
        m_sus2_reg <= m_sus1;
        m_dec2_reg <= m_dec1;
        saw2_reg   <= saw1;
        sqneg2_reg <= a_rdata.phase[PB-1];
    end

    assign rel_p  = (LB+32)'(m_sus2_reg) * (LB+32)'(release_reg);
    assign dec_p  = (LB+33)'(m_dec2_reg) * (LB+33)'(decay_reg);
    assign t_sine = MIX_W'(sine_w_reg) * MIX_W'(sine2);
    assign t_saw  = MIX_W'(saw_w_reg) * MIX_W'(saw2_reg);
    assign t_sq   = sqneg2_reg ? -(MIX_W'(square_w_reg) <<< 15)
                               : (MIX_W'(square_w_reg) <<< 15);
    assign mix2   = t_sine + t_saw + t_sq;

    // ---------------- stage 3: transitions, level, write-back ----------------
    logic                     act3_reg, held3_reg;
    stage_t                   stage3_reg;
    logic [LB-1:0]            pk3_reg, level3_reg, thr3_reg, rel3_reg, dec3_reg;
    logic signed [STEP_W-1:0] step3_reg;
    logic [23:0]              phst3_reg;
    logic [PB-1:0]            newph3_reg;
    logic signed [MIX_W-1:0]  mix3_reg;
    stage_t                   stg3;
    logic signed [STEP_W-1:0] st3;
    logic                     free3;
    logic                     alive3;
    logic signed [LB+1:0]     sum3;
    logic [LB-1:0]            nl3;

    always_ff @(posedge clk)
    begin
        act3_reg   <= act2_reg;
        held3_reg  <= held2_reg;
        idx3_reg   <= idx2_reg;
        stage3_reg <= stage2_reg;
        pk3_reg    <= pk2_reg;
        level3_reg <= level2_reg;
        step3_reg  <= step2_reg;
        phst3_reg  <= phst2_reg;
        newph3_reg <= newph2_reg;
        thr3_reg   <= m_sus2_reg[LB+15:16];
        rel3_reg   <= rel_p[LB+31:32];
        dec3_reg   <= dec_p[LB+31:32];
        mix3_reg   <= mix2;
    end

    always_comb
    begin
        stg3  = stage3_reg;
        st3   = step3_reg;
        free3 = 1'b0;
        if (!held3_reg)
        begin
            stg3 = ST_RELEASE;
            st3  = -$signed({1'b0, rel3_reg});
        end
        case (stg3)
            ST_ATTACK:
            begin
                if (level3_reg >= pk3_reg)
                begin
                    stg3 = ST_DECAY;
                    st3  = -$signed({1'b0, dec3_reg});
                end
            end
            ST_DECAY:
            begin
                if (level3_reg <= thr3_reg)
                begin
                    stg3 = ST_SUSTAIN;
                    st3  = '0;
                end
            end
            ST_SUSTAIN: ;
            ST_RELEASE: free3 = (level3_reg == '0);
            default: ;
        endcase
        alive3 = v3_reg && act3_reg && !free3;
        sum3   = $signed({2'b00, level3_reg}) + (LB+2)'(st3);
        if (sum3 < 0)
        begin
            nl3 = '0;
        end
        else if (sum3 > $signed({2'b00, pk3_reg}))
        begin
            nl3 = pk3_reg;
        end
        else
        begin
            nl3 = sum3[LB-1:0];
        end
    end

    assign wb_we      = alive3;
    assign wb_a.level = nl3;
    assign wb_a.phase = newph3_reg;
    assign wb_b.stage = stg3;
    assign wb_b.pk    = pk3_reg;
    assign wb_b.step  = st3;
    assign wb_b.phst  = phst3_reg;

    // ---------------- stage 4/5: level scaling and accumulate ----------------
    logic                     alive4_reg, alive5_reg;
    logic [LB-1:0]            nl4_reg;
    logic signed [MIX_W-1:0]  mix4_reg;
    logic signed [PROD_W-1:0] prod5_reg;
    logic signed [PROD_W-1:0] prod_sh;
    logic signed [ACC_W-1:0]  acc_reg;
    logic [SLOT_W:0]          count_reg;
    logic signed [GAIN_W-1:0] gprod_reg;
    logic signed [GAIN_W-1:0] gsh;
    logic signed [23:0]       sat;

    always_ff @(posedge clk)
    begin
        alive4_reg <= alive3;
        nl4_reg    <= nl3;
        mix4_reg   <= mix3_reg;
        alive5_reg <= alive4_reg;
        prod5_reg  <= PROD_W'(mix4_reg) * PROD_W'($signed({1'b0, nl4_reg}));
        gprod_reg  <= GAIN_W'(acc_reg) * GAIN_W'($signed({1'b0, gain_reg}));
    end

    assign prod_sh = prod5_reg >>> (LB + 6);
    assign gsh     = gprod_reg >>> 16;

    always_comb
    begin
        if (gsh > SAT_HI)
        begin
            sat = 24'sh7FFFFF;
        end
        else if (gsh < SAT_LO)
        begin
            sat = 24'sh800000;
        end
        else
        begin
            sat = gsh[23:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg     <= '0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            v4_reg    <= 1'b0;
            v5_reg    <= 1'b0;
            acc_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            v1_reg <= issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            if (accept)
            begin
                k_reg     <= '0;
                acc_reg   <= '0;
                count_reg <= '0;
            end
            else
            begin
                if (issue)
                begin
                    k_reg <= k_reg + 1'b1;
                end
                if (alive3)
                begin
                    count_reg <= count_reg + 1'b1;
                end
                if (v5_reg && alive5_reg)
                begin
                    acc_reg <= acc_reg + ACC_W'(prod_sh);
                end
            end
        end
    end

    // ---------------- slot flags ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0;
            held_reg   <= '0;
        end
        else
        begin
            if (accept && req.req_type == REQ_NOTE_OFF && key_ok && active_reg[key_idx])
            begin
                held_reg[key_idx] <= 1'b0;
            end
            if (on_write)
            begin
                active_reg[on_key_reg] <= 1'b1;
                held_reg[on_key_reg]   <= 1'b1;
            end
            if (v3_reg && act3_reg && free3)
            begin
                active_reg[idx3_reg] <= 1'b0;
            end
        end
    end

    // ---------------- response register ----------------
    logic rsp_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (rsp_load)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rsp_load)
        begin
            rsp.sample        <= sat;
            rsp.voices_active <= 9'(count_reg);
        end
    end

    assign rsp_valid = rsp_valid_reg;

endmodule

FILE: rtl/pavm_checker.sv
// Port-level checks for the voice mixer, bound onto the top level.
// Depends on pavm_pkg and polyphonic_adsr_voice_mixer.
module pavm_checker #(
    parameter int VOICE_SLOTS = 256
) (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_ready,
    input pavm_pkg::req_t req,
    input logic           rsp_valid,
    input logic           rsp_ready,
    input pavm_pkg::rsp_t rsp,
    input logic           pready
);

    import pavm_pkg::*;

    // stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response dropped or changed while stalled");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.voices_active <= 9'(VOICE_SLOTS))
        else $error("voice count beyond slot count");

    // note events never produce a response
    a_event_silent: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && req.req_type != REQ_TICK |=> !$rose(rsp_valid))
        else $error("response after a note event");

    // a tick keeps the block busy while it walks the slots
    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && req.req_type == REQ_TICK |=> !req_ready)
        else $error("request taken during slot walk");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

endmodule

bind polyphonic_adsr_voice_mixer pavm_checker #(.VOICE_SLOTS(VOICE_SLOTS)) u_pavm_checker (.*);
